### rtl/has_pkg.sv
// Shared types and constants for the Hall-array steering block.
`timescale 1ns / 1ps
`default_nettype none

package has_pkg;

	localparam int SAMPLE_W     = 12;
	localparam int CHANNELS_DEF = 11;
	localparam int HISTORY_DEF  = 3;

	// register reset values
	localparam logic [15:0] CENTER_PULSE_RST = 16'd1500;
	localparam logic [9:0]  STEP_GAIN_RST    = 10'd80;
	localparam logic [3:0]  CENTER_INDEX_RST = 4'd5;
	localparam logic [11:0] THRESHOLD_RST    = 12'd10;

	typedef enum logic [1:0] {
		REG_CENTER_PULSE = 2'd0,
		REG_STEP_GAIN    = 2'd1,
		REG_CENTER_INDEX = 2'd2,
		REG_THRESHOLD    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_FIN
	} state_t;

	// control from the sweep into the ranking unit
	typedef struct packed {
		logic clear;
		logic push;
	} rank_ctl_t;

endpackage

`default_nettype wire

### rtl/has_rank.sv
// Running top-three ranking and threshold detect over one sweep of smoothed levels.
`timescale 1ns / 1ps
`default_nettype none

module has_rank #(
	parameter int CHANNELS = has_pkg::CHANNELS_DEF,
	parameter int HISTORY  = has_pkg::HISTORY_DEF,
	localparam int IDX_W   = $clog2(CHANNELS),
	localparam int LVL_W   = $clog2(3 * HISTORY * ((1 << has_pkg::SAMPLE_W) - 1) + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire has_pkg::rank_ctl_t ctl,
	input  wire logic [LVL_W-1:0] level,
	input  wire logic [IDX_W-1:0] idx,
	input  wire logic [LVL_W-1:0] limit,
	output logic      [IDX_W-1:0] idx1,
	output logic      [IDX_W-1:0] idx2,
	output logic      [IDX_W-1:0] idx3,
	output logic      [LVL_W-1:0] best1,
	output logic                  any_hit
);
	import has_pkg::*;

	logic             h1_q, h2_q, h3_q, any_q;
	logic [LVL_W-1:0] b1_q, b2_q, b3_q;
	logic [IDX_W-1:0] i1_q, i2_q, i3_q;
	logic             gt1, gt2, gt3;

	// an empty slot beats any level
	assign gt1 = !h1_q || (level > b1_q);
	assign gt2 = !h2_q || (level > b2_q);
	assign gt3 = !h3_q || (level > b3_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h1_q  <= 1'b0;
			h2_q  <= 1'b0;
			h3_q  <= 1'b0;
			any_q <= 1'b0;
		end else if (ctl.clear) begin
			h1_q  <= 1'b0;
			h2_q  <= 1'b0;
			h3_q  <= 1'b0;
			any_q <= 1'b0;
		end else if (ctl.push) begin
			if (level >= limit) begin
				any_q <= 1'b1;
			end
			if (gt1) begin
				h3_q <= h2_q;
				h2_q <= h1_q;
				h1_q <= 1'b1;
			end else if (gt2) begin
				h3_q <= h2_q;
				h2_q <= 1'b1;
			end else if (gt3) begin
				h3_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			i1_q <= '0;
			i2_q <= '0;
			i3_q <= '0;
		end else if (ctl.push) begin
			if (gt1) begin
				b3_q <= b2_q;
				i3_q <= i2_q;
				b2_q <= b1_q;
				i2_q <= i1_q;
				b1_q <= level;
				i1_q <= idx;
			end else if (gt2) begin
				b3_q <= b2_q;
				i3_q <= i2_q;
				b2_q <= level;
				i2_q <= idx;
			end else if (gt3) begin
				b3_q <= level;
				i3_q <= idx;
			end
		end
	end

	assign idx1    = i1_q;
	assign idx2    = i2_q;
	assign idx3    = i3_q;
	assign best1   = b1_q;
	assign any_hit = any_q;

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.push && !ctl.clear) |=> h1_q)
		else $error("rank: push left top slot empty");
	a_order12: assert property (@(posedge clk) disable iff (!arst_n)
		h2_q |-> (h1_q && (b1_q >= b2_q)))
		else $error("rank: first and second out of order");
	a_order23: assert property (@(posedge clk) disable iff (!arst_n)
		h3_q |-> (h2_q && (b2_q >= b3_q)))
		else $error("rank: second and third out of order");

endmodule

`default_nettype wire

### rtl/hall_array_steering.sv
// Top level of the Hall-array steering block: sample capture, history sweep, servo pulse.
//
// Usage:
//   Sample channel (sample_valid / sample_stall): one converter reading per transaction,
//   in scan order, with scan_end on the last channel and active sampled on that one.
//   Result channel (result_valid / result_stall): one transaction per scan_end sample.
//   Config channel (cfg_valid / cfg_ready): register index and data, always ready;
//   write only while the block is idle.
// Sequencing:
//   An inactive scan_end goes straight to the final step, which loads its result. An
//   active scan_end starts a sweep over the channels: one channel per cycle through
//   the scan, offset and history memories (one read port each), then a drain and the
//   final step, which loads the result into the output register. Samples are stalled
//   from the start of that sweep until the final step is done.
// Reset:
//   Registers return to their reset values, history rows read as zero, calibration
//   is cleared. No clearing pass is needed.
// Receiver stall:
//   The result sits in an output register; new samples are taken meanwhile. A later
//   scan_end waits in its final step until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module hall_array_steering #(
	parameter int CHANNELS = has_pkg::CHANNELS_DEF,
	parameter int HISTORY  = has_pkg::HISTORY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sample channel
	input  wire logic        sample_valid,
	output logic             sample_stall,
	input  wire logic [11:0] adc_sample,
	input  wire logic        scan_end,
	input  wire logic        active,
	// result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic      [15:0] pulse_width,
	output logic             centered,
	output logic      [3:0]  top_index,
	output logic      [3:0]  second_index,
	output logic      [3:0]  third_index,
	output logic      [15:0] peak_level,
	// configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import has_pkg::*;

	localparam int SMAX  = (1 << SAMPLE_W) - 1;
	localparam int IDX_W = $clog2(CHANNELS);
	localparam int CNT_W = $clog2(CHANNELS + 1);
	localparam int RP_W  = (HISTORY > 1) ? $clog2(HISTORY) : 1;
	localparam int SUM_W = $clog2(HISTORY * SMAX + 1);
	localparam int LVL_W = $clog2(3 * HISTORY * SMAX + 1);
	localparam int EXT_W = (LVL_W > 16) ? LVL_W : 17;
	localparam logic [IDX_W-1:0] LAST   = IDX_W'(CHANNELS - 1);
	localparam logic [RP_W-1:0]  RP_TOP = RP_W'(HISTORY - 1);

	typedef logic [HISTORY-1:0][SAMPLE_W-1:0] row_t;

	// ---------------- configuration ----------------
	logic [15:0] center_pulse_q;
	logic [9:0]  step_gain_q;
	logic [3:0]  center_index_q;
	logic [11:0] threshold_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_pulse_q <= CENTER_PULSE_RST;
			step_gain_q    <= STEP_GAIN_RST;
			center_index_q <= CENTER_INDEX_RST;
			threshold_q    <= THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTER_PULSE: center_pulse_q <= cfg_data;
				REG_STEP_GAIN:    step_gain_q    <= cfg_data[9:0];
				REG_CENTER_INDEX: center_index_q <= cfg_data[3:0];
				REG_THRESHOLD:    threshold_q    <= cfg_data[11:0];
				default:          ;
			endcase
		end
	end

	// ---------------- control ----------------
	state_t           state_q, state_d;
	logic             sample_acc, issue, out_free, out_load, scan_go;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             act_q, calibrated_q;
	logic [RP_W-1:0]  ring_pos_q;
	logic [LVL_W-1:0] limit_q;
	logic             result_valid_q;

	// pipeline
	logic             v_s1, v_s2, v_s3, tail_q;
	logic [IDX_W-1:0] idx_s1, idx_s2, lidx_s3;
	logic [SAMPLE_W-1:0] scan_rd_s1, off_rd_s1;
	row_t             hist_rd_s1;
	logic             row_ok_s1;
	logic [SUM_W-1:0] sum_s2, prev1_q, prev2_q;
	logic [LVL_W-1:0] lvl_s3;

	assign sample_acc = sample_valid && !sample_stall;
	assign scan_go    = sample_acc && scan_end;
	assign out_free   = !result_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (scan_go) begin
					state_d = active ? ST_SWEEP : ST_FIN;
				end
			end
			ST_SWEEP: begin
				if (rd_idx_q == LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// tail level of the last channel has reached the ranker
				if (v_s3 && (lidx_s3 == LAST)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_stall = 1'b1;
		issue        = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE:  sample_stall = 1'b0;
			ST_SWEEP: issue = 1'b1;
			ST_DRAIN: ;
			ST_FIN:   out_load = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			rd_idx_q     <= '0;
			act_q        <= 1'b0;
			calibrated_q <= 1'b0;
			ring_pos_q   <= '0;
		end else begin
			state_q <= state_d;
			if (sample_acc) begin
				if (scan_end) begin
					cnt_q <= '0;
				end else if (cnt_q < CNT_W'(CHANNELS)) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			// read index parks on the last channel so reads stay inside the arrays
			if (scan_go) begin
				act_q    <= active;
				rd_idx_q <= '0;
			end else if (issue && (rd_idx_q != LAST)) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			// calibration and ring advance take effect once the sweep has used them
			if (out_load && act_q) begin
				calibrated_q <= 1'b1;
				ring_pos_q   <= (ring_pos_q == RP_TOP) ? '0 : ring_pos_q + RP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_go) begin
			limit_q <= LVL_W'(threshold_q * (3 * HISTORY));
		end
	end

	// ---------------- memories ----------------
	logic [SAMPLE_W-1:0] scan_mem [CHANNELS];
	logic [SAMPLE_W-1:0] off_mem  [CHANNELS];
	row_t                hist_mem [CHANNELS];
	logic [CHANNELS-1:0] hist_vld_q;

	logic                scan_we;
	row_t                new_row;

	// a scan longer than the array drops the extra samples
	assign scan_we = sample_acc && (cnt_q < CNT_W'(CHANNELS));

	always_ff @(posedge clk) begin
		if (scan_we) begin
			scan_mem[cnt_q[IDX_W-1:0]] <= adc_sample;
		end
		scan_rd_s1 <= scan_mem[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (v_s1 && !calibrated_q) begin
			off_mem[idx_s1] <= scan_rd_s1;
		end
		off_rd_s1 <= off_mem[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			hist_mem[idx_s1] <= new_row;
		end
		hist_rd_s1 <= hist_mem[rd_idx_q];
	end

	// history rows read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			row_ok_s1  <= 1'b0;
		end else begin
			row_ok_s1 <= hist_vld_q[rd_idx_q];
			if (v_s1) begin
				hist_vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	// ---------------- stage 1: level, ring update, ring sum ----------------
	logic [SAMPLE_W-1:0] off_use, mag;
	logic [SAMPLE_W:0]   diff;
	row_t                old_row;
	logic [SUM_W-1:0]    row_sum;

	always_comb begin
		// first active scan: the scan is its own offset
		off_use = calibrated_q ? off_rd_s1 : scan_rd_s1;
		diff    = {1'b0, scan_rd_s1} - {1'b0, off_use};
		mag     = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
		old_row = row_ok_s1 ? hist_rd_s1 : '0;
		row_sum = '0;
		for (int k = 0; k < HISTORY; k++) begin
			new_row[k] = (RP_W'(k) == ring_pos_q) ? mag : old_row[k];
			row_sum    = row_sum + SUM_W'(new_row[k]);
		end
	end

	// ---------------- stage 2: three-tap window ----------------
	logic [SUM_W-1:0] op_a, op_b, op_c;
	logic [IDX_W-1:0] emit_idx;
	logic             emit;

	always_comb begin
		emit     = tail_q || (v_s2 && (idx_s2 != '0));
		op_a     = prev2_q;
		op_b     = prev1_q;
		op_c     = sum_s2;
		emit_idx = idx_s2 - IDX_W'(1);
		if (tail_q) begin
			// right edge counts itself twice
			op_a     = prev1_q;
			op_c     = prev2_q;
			emit_idx = LAST;
		end else if (idx_s2 == IDX_W'(1)) begin
			// left edge counts itself twice
			op_a     = prev1_q;
			emit_idx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			tail_q <= 1'b0;
		end else begin
			v_s1   <= issue;
			v_s2   <= v_s1;
			v_s3   <= emit;
			tail_q <= v_s2 && (idx_s2 == LAST);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		idx_s2 <= idx_s1;
		sum_s2 <= row_sum;
		if (v_s2) begin
			prev2_q <= prev1_q;
			prev1_q <= sum_s2;
		end
		lvl_s3  <= LVL_W'(op_a) + LVL_W'(op_b) + LVL_W'(op_c);
		lidx_s3 <= emit_idx;
	end

	// ---------------- stage 3: ranking ----------------
	rank_ctl_t        rank_ctl;
	logic [IDX_W-1:0] r_idx1, r_idx2, r_idx3;
	logic [LVL_W-1:0] r_best;
	logic             r_any;

	assign rank_ctl.clear = scan_go && active;
	assign rank_ctl.push  = v_s3;

	has_rank #(
		.CHANNELS(CHANNELS),
		.HISTORY (HISTORY)
	) u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rank_ctl),
		.level  (lvl_s3),
		.idx    (lidx_s3),
		.limit  (limit_q),
		.idx1   (r_idx1),
		.idx2   (r_idx2),
		.idx3   (r_idx3),
		.best1  (r_best),
		.any_hit(r_any)
	);

	// ---------------- result ----------------
	logic signed [4:0]  off_ch;
	logic signed [15:0] prod;
	logic signed [17:0] pulse_sum;
	logic [15:0]        pulse_sat;
	logic [EXT_W-1:0]   best_ext;
	logic [15:0]        peak_sat;

	always_comb begin
		off_ch    = $signed({1'b0, 4'(r_idx1)}) - $signed({1'b0, center_index_q});
		prod      = 16'(off_ch) * 16'($signed({1'b0, step_gain_q}));
		pulse_sum = $signed({2'b00, center_pulse_q}) + $signed({{2{prod[15]}}, prod});
		if (pulse_sum[17]) begin
			pulse_sat = '0;
		end else if (pulse_sum[16]) begin
			pulse_sat = 16'hFFFF;
		end else begin
			pulse_sat = pulse_sum[15:0];
		end
		best_ext = EXT_W'(r_best);
		peak_sat = (best_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF : best_ext[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (!act_q) begin
				pulse_width  <= center_pulse_q;
				centered     <= 1'b1;
				top_index    <= '0;
				second_index <= '0;
				third_index  <= '0;
				peak_level   <= '0;
			end else begin
				pulse_width  <= r_any ? pulse_sat : center_pulse_q;
				centered     <= !r_any;
				top_index    <= 4'(r_idx1);
				second_index <= 4'(r_idx2);
				third_index  <= 4'(r_idx3);
				peak_level   <= peak_sat;
			end
		end
	end

	assign result_valid = result_valid_q;

	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> !(v_s1 || v_s2 || v_s3 || tail_q))
		else $error("sweep pipeline not empty at final step");
	a_emit_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ((state_q == ST_SWEEP) || (state_q == ST_DRAIN)))
		else $error("level emitted outside a sweep");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (result_valid && (state_q == ST_IDLE)))
		else $error("loaded result not presented");
	a_no_issue_past_end: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && (rd_idx_q == LAST)) |=> (state_q == ST_DRAIN))
		else $error("sweep ran past last channel");

endmodule

`default_nettype wire
